// ----- rtl/byte_ring_fifo_unit_assert.svh -----
// assertion macros shared by the byte ring fifo checker
`ifndef BYTE_RING_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define BRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("byte ring fifo check failed");

// next-cycle implication, sampled on the rising clock, off during reset
`define BRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("byte ring fifo check failed");

`endif

// ----- rtl/brf_pkg.sv -----
// shared types and command codes for the byte ring fifo
`default_nettype none

package brf_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // reset value of the size register
  localparam logic [8:0] SIZE_RESET = 9'd256;

  // store access strobes for one transaction
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } brf_mem_ctl_t;

  // result fields other than the read byte
  typedef struct packed {
    logic       done;
    logic [7:0] fill;
    logic [7:0] free;
    logic       empty;
    logic [7:0] block_count;
  } brf_result_t;

endpackage

`default_nettype wire

// ----- rtl/byte_ring_fifo_unit.sv -----
// Byte ring fifo top level: command input, result output, size register.
//
// Input channel (in_valid/in_stall) carries one command per transaction:
// write data_in, read the oldest byte, or clear both indices. Every command
// gives exactly one result on the output channel (out_valid/out_stall) with
// the read byte, a done flag, fill and free counts, an empty flag and the
// running byte count of the current block.
// The result is registered: a command accepted at one edge shows its result
// from the next cycle. One command per cycle is sustained; the single
// result register sets this, and the input stalls only while that register
// holds a result that the receiver is stalling.
// The store keeps STORE_DEPTH bytes; size_in_use (cfg_wr_en/cfg_wr_data)
// selects how many slots are used, one slot always staying empty.
// Reset (rst, synchronous) empties the fifo, zeroes the block count, sets
// the size to 256 and drops any pending result; store contents are kept.
`default_nettype none

module byte_ring_fifo_unit #(
  parameter int STORE_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] cmd,
  input  logic [7:0] data_in,
  input  logic       last_of_block,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_out,
  output logic       done_res,
  output logic [7:0] fill_count,
  output logic [7:0] free_count,
  output logic       is_empty,
  output logic [7:0] block_done_count,
  input  logic       cfg_wr_en,
  input  logic [8:0] cfg_wr_data
);
  import brf_pkg::*;

  localparam int IW = $clog2(STORE_DEPTH);

  logic [IW-1:0] read_index;
  logic [IW-1:0] write_index;
  logic [7:0]    block_tally;
  logic [8:0]    size_in_use;
  logic [IW-1:0] read_index_next;
  logic [IW-1:0] write_index_next;
  logic [7:0]    block_tally_next;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  brf_mem_ctl_t  mem_ctl;
  brf_result_t   result_next;
  brf_result_t   result;
  logic          rd_flag;
  logic [7:0]    rd_data;
  logic          in_acc;

  // accept whenever the result register is free or drains this cycle
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  brf_step #(
    .DEPTH (STORE_DEPTH)
  ) u_step (
    .size_in_use      (size_in_use),
    .read_index       (read_index),
    .write_index      (write_index),
    .block_tally      (block_tally),
    .cmd              (cmd),
    .last_of_block    (last_of_block),
    .read_index_next  (read_index_next),
    .write_index_next (write_index_next),
    .block_tally_next (block_tally_next),
    .rd_addr          (rd_addr),
    .wr_addr          (wr_addr),
    .mem_ctl          (mem_ctl),
    .result           (result_next)
  );

  brf_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc && mem_ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_in),
    .rd_en   (in_acc && mem_ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_in_use <= cfg_wr_data;
    end
  end

  // fifo state
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      block_tally <= '0;
    end else if (in_acc) begin
      read_index  <= read_index_next;
      write_index <= write_index_next;
      block_tally <= block_tally_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      result  <= result_next;
      rd_flag <= mem_ctl.rd_en;
    end
  end

  assign data_out         = rd_flag ? rd_data : 8'd0;
  assign done_res         = result.done;
  assign fill_count       = result.fill;
  assign free_count       = result.free;
  assign is_empty         = result.empty;
  assign block_done_count = result.block_count;

endmodule

`default_nettype wire

// ----- rtl/brf_store.sv -----
// byte store: one write port, one read port with registered read data
`default_nettype none

module brf_store #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/brf_step.sv -----
// next index, tally and result fields for one command
`default_nettype none

module brf_step #(
  parameter int DEPTH = 256,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic [8:0]           size_in_use,
  input  logic [IW-1:0]        read_index,
  input  logic [IW-1:0]        write_index,
  input  logic [7:0]           block_tally,
  input  logic [1:0]           cmd,
  input  logic                 last_of_block,
  output logic [IW-1:0]        read_index_next,
  output logic [IW-1:0]        write_index_next,
  output logic [7:0]           block_tally_next,
  output logic [IW-1:0]        rd_addr,
  output logic [IW-1:0]        wr_addr,
  output brf_pkg::brf_mem_ctl_t mem_ctl,
  output brf_pkg::brf_result_t  result
);
  import brf_pkg::*;

  localparam int CW = (IW + 1 > 9) ? IW + 1 : 9;

  logic [CW-1:0] sz;
  logic [CW-1:0] eff;
  logic [IW-1:0] rix;
  logic [IW-1:0] wix;
  logic [CW-1:0] fill_pre;
  logic [CW-1:0] free_pre;
  logic [CW-1:0] fill_post;
  logic [CW-1:0] free_post;
  logic [CW-1:0] rix_inc;
  logic [CW-1:0] wix_inc;
  logic [IW-1:0] rix_wrap;
  logic [IW-1:0] wix_wrap;
  logic          done;
  logic [7:0]    tally_inc;

  function automatic logic [CW-1:0] fill_of(input logic [IW-1:0] r, input logic [IW-1:0] w,
                                            input logic [CW-1:0] s);
    if (w >= r) begin
      return CW'(w) - CW'(r);
    end
    return s - (CW'(r) - CW'(w));
  endfunction

  function automatic logic [7:0] sat8(input logic [CW-1:0] v);
    return (v > CW'(255)) ? 8'hFF : v[7:0];
  endfunction

  // effective size, clamped to at least 2 and at most the store depth
  always_comb begin
    sz = CW'(size_in_use);
    if (sz < CW'(2)) begin
      eff = CW'(2);
    end else if (sz > CW'(DEPTH)) begin
      eff = CW'(DEPTH);
    end else begin
      eff = sz;
    end
  end

  // indices folded back into range, levels before the command
  always_comb begin
    rix      = (CW'(read_index) >= eff) ? '0 : read_index;
    wix      = (CW'(write_index) >= eff) ? '0 : write_index;
    fill_pre = fill_of(rix, wix, eff);
    free_pre = eff - CW'(1) - fill_pre;
    rix_inc  = CW'(rix) + CW'(1);
    wix_inc  = CW'(wix) + CW'(1);
    rix_wrap = (rix_inc >= eff) ? '0 : rix_inc[IW-1:0];
    wix_wrap = (wix_inc >= eff) ? '0 : wix_inc[IW-1:0];
  end

  // command decode
  always_comb begin
    read_index_next  = rix;
    write_index_next = wix;
    done             = 1'b0;
    mem_ctl          = '0;
    case (cmd)
      CMD_WRITE: begin
        if (free_pre != '0) begin
          write_index_next = wix_wrap;
          done             = 1'b1;
          mem_ctl.wr_en    = 1'b1;
        end
      end
      CMD_READ: begin
        if (fill_pre != '0) begin
          read_index_next = rix_wrap;
          done            = 1'b1;
          mem_ctl.rd_en   = 1'b1;
        end
      end
      CMD_CLEAR: begin
        read_index_next  = '0;
        write_index_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign rd_addr = rix;
  assign wr_addr = wix;

  // block tally, restarts after the last transaction of a block
  assign tally_inc        = (done && block_tally != 8'hFF) ? block_tally + 8'd1 : block_tally;
  assign block_tally_next = last_of_block ? 8'd0 : tally_inc;

  // levels after the command
  always_comb begin
    fill_post          = fill_of(read_index_next, write_index_next, eff);
    free_post          = eff - CW'(1) - fill_post;
    result.done        = done;
    result.fill        = sat8(fill_post);
    result.free        = sat8(free_post);
    result.empty       = (read_index_next == write_index_next);
    result.block_count = tally_inc;
  end

endmodule

`default_nettype wire

// ----- rtl/brf_checker.sv -----
// port-level checks for the byte ring fifo and their binding
`default_nettype none

`include "byte_ring_fifo_unit_assert.svh"

module brf_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] data_out,
  input logic       done_res,
  input logic [7:0] fill_count,
  input logic [7:0] free_count,
  input logic       is_empty,
  input logic [7:0] block_done_count
);

  // input stalls exactly while a result waits on a stalled receiver
  `BRF_ASSERT_IMP(a_stall_rule, 1'b1, in_stall == (out_valid && out_stall))

  // empty flag agrees with the fill count
  `BRF_ASSERT_IMP(a_empty_fill, out_valid, is_empty == (fill_count == 8'd0))

  // a transaction that did nothing returns a zero byte
  `BRF_ASSERT_IMP(a_idle_zero, out_valid && !done_res, data_out == 8'd0)

  // a stalled result holds
  `BRF_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(data_out) && $stable(fill_count) &&
                  $stable(free_count) && $stable(block_done_count))

endmodule

bind byte_ring_fifo_unit brf_checker u_brf_checker (.*);

`default_nettype wire
